// ===== hdl/u8w_pkg.sv =====
// Shared types, constants and the cell width lookup for the UTF-8 width counter.
// Used by u8w_front, u8w_queue, u8w_back and utf8_display_width_counter.
package u8w_pkg;

    // Accumulator size; the count limit never exceeds the 16-bit result field.
    localparam int SUM_BITS  = 16;
    localparam int CNT_W     = (SUM_BITS < 16) ? SUM_BITS : 16;
    localparam int CP_W      = 21;
    localparam int EXTRA_W   = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // Sequence lengths
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // One classified word handed from front to back
    typedef struct packed {
        logic [CP_W-1:0]    cp;      // code point to look up
        logic               use_cp;  // cp carries a width to add
        logic [EXTRA_W-1:0] extra;   // cells for broken or invalid bytes
        logic               last;    // end of string: emit and clear
    } t_u8w_rec;

    function automatic logic in_rng(logic [CP_W-1:0] c, logic [CP_W-1:0] lo,
                                    logic [CP_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // Terminal cell width of a valid code point
    function automatic logic [1:0] glyph_width(logic [CP_W-1:0] c);
        logic zero_w;
        logic wide;
        zero_w = (c < 21'h20) || in_rng(c, 21'h7F, 21'h9F)
              || in_rng(c, 21'h0300, 21'h036F) || in_rng(c, 21'h1AB0, 21'h1AFF)
              || in_rng(c, 21'h1DC0, 21'h1DFF) || in_rng(c, 21'h20D0, 21'h20FF)
              || in_rng(c, 21'hFE20, 21'hFE2F);
        wide = in_rng(c, 21'h1100, 21'h115F) || (c == 21'h2329) || (c == 21'h232A)
            || (in_rng(c, 21'h2E80, 21'hA4CF) && (c != 21'h303F))
            || in_rng(c, 21'hAC00, 21'hD7A3) || in_rng(c, 21'hF900, 21'hFAFF)
            || in_rng(c, 21'hFE10, 21'hFE19) || in_rng(c, 21'hFE30, 21'hFE6F)
            || in_rng(c, 21'hFF00, 21'hFF60) || in_rng(c, 21'hFFE0, 21'hFFE6)
            || in_rng(c, 21'h1F300, 21'h1F64F) || in_rng(c, 21'h1F900, 21'h1F9FF);
        if (zero_w) begin
            return 2'd0;
        end else if (wide) begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

endpackage

// ===== hdl/u8w_front.sv =====
// Front end: takes bytes, tracks the pending UTF-8 sequence and classifies each
// byte into a record for the back end. Depends on u8w_pkg.
module u8w_front import u8w_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_u8w_rec   o_rec
);

    logic [2:0]      r_len,  n_len;
    logic [1:0]      r_seen, n_seen;
    logic [CP_W-1:0] r_part, n_part;

    logic            pending;
    logic            cont;
    logic [2:0]      seen_inc;
    logic [CP_W-1:0] cp_next;
    logic            bad;
    t_u8w_rec        rec;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_rec   = rec;

    always_comb begin
        pending  = (r_len != SEQ_NONE);
        cont     = (i_byte[7:6] == 2'b10);
        seen_inc = {1'b0, r_seen} + 3'd1;
        cp_next  = {r_part[CP_W-7:0], i_byte[5:0]};
        bad = ((r_len == SEQ_LEN2) && (cp_next < 21'h80))
           || ((r_len == SEQ_LEN3) && (cp_next < 21'h800))
           || ((r_len == SEQ_LEN4) && (cp_next < 21'h10000))
           || in_rng(cp_next, 21'hD800, 21'hDFFF)
           || (cp_next > 21'h10FFFF);

        n_len  = r_len;
        n_seen = r_seen;
        n_part = r_part;
        rec    = '0;
        rec.last = i_last;

        if (pending && cont) begin
            if (seen_inc == r_len) begin
                // sequence complete
                if (bad) begin
                    rec.extra = r_len;
                end else begin
                    rec.use_cp = 1'b1;
                    rec.cp     = cp_next;
                end
                n_len  = SEQ_NONE;
                n_seen = 2'd0;
                n_part = '0;
            end else begin
                n_seen = seen_inc[1:0];
                n_part = cp_next;
                if (i_last) begin
                    rec.extra = seen_inc;
                end
            end
        end else begin
            // no sequence open, or a broken one: pending bytes count one each, byte is a new lead
            rec.extra = pending ? {1'b0, r_seen} : '0;
            n_len  = SEQ_NONE;
            n_seen = 2'd0;
            n_part = '0;
            unique case (i_byte) inside
                8'b0???????: begin
                    rec.use_cp = 1'b1;
                    rec.cp     = {{(CP_W-8){1'b0}}, i_byte};
                end
                8'b110?????: begin
                    n_len  = SEQ_LEN2;
                    n_seen = 2'd1;
                    n_part = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                end
                8'b1110????: begin
                    n_len  = SEQ_LEN3;
                    n_seen = 2'd1;
                    n_part = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                end
                8'b11110???: begin
                    n_len  = SEQ_LEN4;
                    n_seen = 2'd1;
                    n_part = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                end
                default: begin
                    rec.extra = rec.extra + 3'd1;
                end
            endcase
            // a lead left open at the end counts one
            if (i_last && (n_len != SEQ_NONE)) begin
                rec.extra = rec.extra + 3'd1;
            end
        end

        if (i_last) begin
            n_len  = SEQ_NONE;
            n_seen = 2'd0;
            n_part = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= SEQ_NONE;
            r_seen <= 2'd0;
            r_part <= '0;
        end else if (o_push) begin
            r_len  <= n_len;
            r_seen <= n_seen;
            r_part <= n_part;
        end
    end

endmodule

// ===== hdl/u8w_queue.sv =====
// Short FIFO of classified records between front and back end.
// Depends on u8w_pkg.
module u8w_queue import u8w_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_u8w_rec i_rec,
    output logic     o_full,
    output logic     o_valid,
    output t_u8w_rec o_rec,
    input  logic     i_pop
);

    t_u8w_rec            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]  r_cnt,    n_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== hdl/u8w_back.sv =====
// Back end: looks up cell widths, keeps the saturating sum and holds the
// result word in an output register. Depends on u8w_pkg.
module u8w_back import u8w_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_u8w_rec    i_rec,
    output logic        o_pop,
    output logic        o_out_valid,
    output logic [15:0] o_count,
    output logic        o_sat,
    input  logic        i_out_ready
);

    logic [CNT_W-1:0] r_total;
    logic             r_ovf;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_sat;

    logic [1:0]       w;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] n_total;
    logic             n_ovf;

    assign o_out_valid = r_out_valid;
    assign o_count     = 16'(r_out_count);
    assign o_sat       = r_out_sat;

    // A non-final word never waits; the final one needs the output slot.
    assign o_pop = i_valid && (!i_rec.last || !r_out_valid || i_out_ready);

    always_comb begin
        w   = i_rec.use_cp ? glyph_width(i_rec.cp) : 2'd0;
        sum = {1'b0, r_total} + (CNT_W+1)'(w) + (CNT_W+1)'(i_rec.extra);
        // limit is all ones, so the carry bit marks overflow
        if (sum[CNT_W]) begin
            n_total = '1;
            n_ovf   = 1'b1;
        end else begin
            n_total = sum[CNT_W-1:0];
            n_ovf   = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_rec.last) begin
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_ovf   <= n_ovf;
                end
            end
            if (o_pop && i_rec.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_rec.last) begin
            r_out_count <= n_total;
            r_out_sat   <= n_ovf;
        end
    end

endmodule

// ===== hdl/utf8_display_width_counter.sv =====
// UTF-8 display width counter, top level.
// Depends on u8w_pkg, u8w_front, u8w_queue and u8w_back.
//
// Takes a UTF-8 string one byte per word on the slave stream (tlast marks the
// final byte) and returns one word per string on the master stream: the total
// terminal cell width, saturated at 0xFFFF (or 2^SUM_BITS-1 if smaller), and
// a flag set if the sum went above that limit. Control codes and combining
// marks count 0, East Asian wide and emoji ranges 2, other valid code points 1.
// Every byte of an invalid, overlong, surrogate, out-of-range or broken
// sequence counts 1; a byte that breaks a sequence is decoded again as a lead.
// Bytes still pending at tlast count 1 each. Throughput is one byte per
// cycle while the queue is not full: the front decoder registers sequence
// state once per byte, and the back adder folds one width per cycle unless
// a final word waits. The last byte enters the queue when accepted and the
// result register loads when the adder pops it. A two-deep queue between
// decoder and adder lets each side stall on its own, so bytes keep flowing
// while a finished result waits to be taken; only once the next string's
// final byte reaches the adder does the queue fill and stall input.
module utf8_display_width_counter import u8w_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: one string byte per word
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // string_end
    // master stream: one result per string
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [15:0] cell_count, [16] count_saturated
);

    t_u8w_rec    front_rec;
    t_u8w_rec    queue_rec;
    logic        push;
    logic        full;
    logic        q_valid;
    logic        pop;
    logic [15:0] count;
    logic        sat;

    u8w_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_ready (o_s_tready),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (front_rec)
    );

    u8w_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .o_valid (q_valid),
        .o_rec   (queue_rec),
        .i_pop   (pop)
    );

    u8w_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_rec       (queue_rec),
        .o_pop       (pop),
        .o_out_valid (o_m_tvalid),
        .o_count     (count),
        .o_sat       (sat),
        .i_out_ready (i_m_tready)
    );

    assign o_m_tdata = {7'd0, sat, count};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_display_width_counter.
// Depends on u8w_pkg and the counter RTL; streams UTF-8 text in as words and
// checks each string total against a decoder model kept in this file.
module tb_top;
    import u8w_pkg::*;

    typedef struct packed {
        logic        sat;
        logic [15:0] cells;
    } t_width_total;

    // Count ceiling seen at the result field
    localparam int unsigned CELL_LIMIT = (1 << CNT_W) - 1;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    // Decoder model state
    logic [2:0]   dec_len  = SEQ_NONE;
    logic [2:0]   dec_seen = 3'd0;
    logic [20:0]  dec_cp   = '0;
    int unsigned  dec_sum  = 0;
    logic         dec_sat  = 1'b0;

    t_width_total expected_totals[$];
    logic [7:0]   pending_text[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int bytes_sent     = 0;
    int strings_sent   = 0;
    int totals_checked = 0;
    int saturated_seen = 0;
    int mismatches     = 0;

    utf8_display_width_counter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("timeout: %0d totals still awaited", expected_totals.size());
        $display("** utf8_display_width_counter: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic logic between(input logic [20:0] c, input logic [20:0] lo,
                                     input logic [20:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic int unsigned cells_of(input logic [20:0] c);
        if (c < 21'h20 || between(c, 21'h7F, 21'h9F)) begin
            return 0;
        end
        // combining marks
        if (between(c, 21'h0300, 21'h036F) || between(c, 21'h1AB0, 21'h1AFF) ||
            between(c, 21'h1DC0, 21'h1DFF) || between(c, 21'h20D0, 21'h20FF) ||
            between(c, 21'hFE20, 21'hFE2F)) begin
            return 0;
        end
        if (between(c, 21'h1100, 21'h115F) || c == 21'h2329 || c == 21'h232A ||
            (between(c, 21'h2E80, 21'hA4CF) && c != 21'h303F) ||
            between(c, 21'hAC00, 21'hD7A3) || between(c, 21'hF900, 21'hFAFF) ||
            between(c, 21'hFE10, 21'hFE19) || between(c, 21'hFE30, 21'hFE6F) ||
            between(c, 21'hFF00, 21'hFF60) || between(c, 21'hFFE0, 21'hFFE6) ||
            between(c, 21'h1F300, 21'h1F64F) || between(c, 21'h1F900, 21'h1F9FF)) begin
            return 2;
        end
        return 1;
    endfunction

    function automatic void add_cells(input int unsigned n);
        if (dec_sum + n > CELL_LIMIT) begin
            dec_sum = CELL_LIMIT;
            dec_sat = 1'b1;
        end else begin
            dec_sum = dec_sum + n;
        end
    endfunction

    function automatic void drop_sequence();
        dec_len  = SEQ_NONE;
        dec_seen = 3'd0;
        dec_cp   = '0;
    endfunction

    function automatic void decode_lead(input logic [7:0] b);
        if (b < 8'h80) begin
            add_cells(cells_of({13'd0, b}));
        end else if ((b & 8'hE0) == 8'hC0) begin
            dec_len  = SEQ_LEN2;
            dec_seen = 3'd1;
            dec_cp   = {16'd0, b[4:0]};
        end else if ((b & 8'hF0) == 8'hE0) begin
            dec_len  = SEQ_LEN3;
            dec_seen = 3'd1;
            dec_cp   = {17'd0, b[3:0]};
        end else if ((b & 8'hF8) == 8'hF0) begin
            dec_len  = SEQ_LEN4;
            dec_seen = 3'd1;
            dec_cp   = {18'd0, b[2:0]};
        end else begin
            add_cells(1);  // stray continuation or 0xF8..0xFF
        end
    endfunction

    // Fold one accepted word into the model; a final byte queues a total.
    function automatic void predict_word(input logic [7:0] b, input logic last);
        logic         bad;
        t_width_total tot;
        if (dec_len != SEQ_NONE) begin
            if (b[7:6] != 2'b10) begin
                // sequence broken: count what was pending, then treat as a lead
                add_cells(32'(dec_seen));
                drop_sequence();
                decode_lead(b);
            end else begin
                dec_cp   = {dec_cp[14:0], b[5:0]};
                dec_seen = dec_seen + 3'd1;
                if (dec_seen >= dec_len) begin
                    bad = (dec_len == SEQ_LEN2 && dec_cp < 21'h80) ||
                          (dec_len == SEQ_LEN3 && dec_cp < 21'h800) ||
                          (dec_len == SEQ_LEN4 && dec_cp < 21'h10000) ||
                          between(dec_cp, 21'hD800, 21'hDFFF) || dec_cp > 21'h10FFFF;
                    add_cells(bad ? 32'(dec_len) : cells_of(dec_cp));
                    drop_sequence();
                end
            end
        end else begin
            decode_lead(b);
        end
        if (last) begin
            if (dec_len != SEQ_NONE) begin
                add_cells(32'(dec_seen));
            end
            tot.cells = dec_sum[15:0];
            tot.sat   = dec_sat;
            expected_totals.insert(expected_totals.size(), tot);
            strings_sent++;
            drop_sequence();
            dec_sum = 0;
            dec_sat = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------ text build

    function automatic void append_text(input logic [7:0] b);
        pending_text.insert(pending_text.size(), b);
    endfunction

    // UTF-8 shape of c in n bytes; n need not be the shortest form.
    function automatic void push_utf8(input logic [20:0] c, input int n);
        case (n)
            1: append_text({1'b0, c[6:0]});
            2: begin
                append_text({3'b110, c[10:6]});
                append_text({2'b10, c[5:0]});
            end
            3: begin
                append_text({4'b1110, c[15:12]});
                append_text({2'b10, c[11:6]});
                append_text({2'b10, c[5:0]});
            end
            default: begin
                append_text({5'b11110, c[20:18]});
                append_text({2'b10, c[17:12]});
                append_text({2'b10, c[11:6]});
                append_text({2'b10, c[5:0]});
            end
        endcase
    endfunction

    function automatic int utf8_len(input logic [20:0] c);
        if (c < 21'h80) return 1;
        if (c < 21'h800) return 2;
        if (c < 21'h10000) return 3;
        return 4;
    endfunction

    // Width table ranges plus the encoding length bands, as {lo, hi}
    function automatic logic [41:0] width_range(input int idx);
        case (idx)
            0:  return {21'h00000, 21'h0001F};
            1:  return {21'h0007F, 21'h0009F};
            2:  return {21'h00300, 21'h0036F};
            3:  return {21'h01AB0, 21'h01AFF};
            4:  return {21'h01DC0, 21'h01DFF};
            5:  return {21'h020D0, 21'h020FF};
            6:  return {21'h0FE20, 21'h0FE2F};
            7:  return {21'h01100, 21'h0115F};
            8:  return {21'h02329, 21'h0232A};
            9:  return {21'h02E80, 21'h0A4CF};
            10: return {21'h0303F, 21'h0303F};
            11: return {21'h0AC00, 21'h0D7A3};
            12: return {21'h0F900, 21'h0FAFF};
            13: return {21'h0FE10, 21'h0FE19};
            14: return {21'h0FE30, 21'h0FE6F};
            15: return {21'h0FF00, 21'h0FF60};
            16: return {21'h0FFE0, 21'h0FFE6};
            17: return {21'h1F300, 21'h1F64F};
            18: return {21'h1F900, 21'h1F9FF};
            19: return {21'h00080, 21'h007FF};
            20: return {21'h00800, 21'h0FFFF};
            default: return {21'h10000, 21'h10FFFF};
        endcase
    endfunction

    // A valid scalar value, weighted towards ASCII and the width boundaries.
    function automatic logic [20:0] pick_codepoint();
        logic [41:0] rng;
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] c;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 35) begin
            c = 21'($urandom_range(8'h7E, 8'h20));
        end else if (sel < 45) begin
            c = $urandom_range(1) ? 21'($urandom_range(8'h1F, 0))
                                  : 21'($urandom_range(8'h9F, 8'h7F));
        end else if (sel < 55) begin
            c = 21'($urandom_range(21'h10FFFF, 0));
        end else begin
            rng = width_range($urandom_range(21));
            lo  = rng[41:21];
            hi  = rng[20:0];
            case ($urandom_range(4))
                0:       c = lo - 21'd1;
                1:       c = lo;
                2:       c = hi;
                3:       c = hi + 21'd1;
                default: c = 21'($urandom_range(hi, lo));
            endcase
        end
        if (c > 21'h10FFFF) c = 21'h10FFFF;
        if (between(c, 21'hD800, 21'hDFFF)) c = c - 21'h800;
        return c;
    endfunction

    function automatic void push_noise();
        logic [20:0] c;
        int          n;
        case ($urandom_range(6))
            0: append_text(8'($urandom_range(255)));
            1: append_text(8'($urandom_range(8'hBF, 8'h80)));
            2: append_text(8'($urandom_range(8'hFF, 8'hF8)));
            3: begin
                // overlong: value fits a shorter form
                n = $urandom_range(4, 2);
                c = 21'($urandom_range(n == 2 ? 'h7F : (n == 3 ? 'h7FF : 'hFFFF)));
                push_utf8(c, n);
            end
            4: push_utf8(21'($urandom_range(21'hDFFF, 21'hD800)), 3);
            5: push_utf8(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
            default: begin
                // truncated sequence: broken by what follows, or open at the end
                c = pick_codepoint();
                n = utf8_len(c);
                if (n == 1) begin
                    append_text(8'hC3);
                end else begin
                    push_utf8(c, n);
                    repeat ($urandom_range(n - 1, 1)) begin
                        pending_text.delete(pending_text.size() - 1);
                    end
                end
            end
        endcase
    endfunction

    // --------------------------------------------------------------- driving

    task automatic send_byte(input logic [7:0] b, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_word(b, last);
        bytes_sent++;
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic send_pending();
        logic [7:0] b;
        while (pending_text.size() != 0) begin
            b = pending_text.pop_front();
            send_byte(b, pending_text.size() == 0);
        end
    endtask

    // Bytes taken from the top of bits downward, last one flagged
    task automatic send_packed(input logic [63:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--) append_text(bits[8*i +: 8]);
        send_pending();
    endtask

    task automatic wait_for_totals();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_totals.size() != 0) @(posedge clk);
    endtask

    // --------------------------------------------------------------- checker

    always @(posedge clk) begin
        t_width_total want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_totals.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected total word: cells %0d sat %0b",
                             m_tdata[15:0], m_tdata[16]);
                end
                mismatches++;
            end else begin
                want = expected_totals.pop_front();
                totals_checked++;
                if (want.sat) saturated_seen++;
                if (m_tdata[15:0] !== want.cells || m_tdata[16] !== want.sat) begin
                    if (mismatches < 10) begin
                        $display("total %0d: expected cells %0d sat %0b, got cells %0d sat %0b",
                                 totals_checked, want.cells, want.sat,
                                 m_tdata[15:0], m_tdata[16]);
                    end
                    mismatches++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ----------------------------------------------------------------- tests

    task automatic test_directed_cases();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_packed(64'h00, 1);              // NUL, zero width
        send_packed(64'hFF, 1);              // invalid lead
        send_packed(64'h41_CC80_E4B880, 6);  // ASCII, combining mark, CJK ideograph
        send_packed(64'hF09F9880, 4);        // emoji
        send_packed(64'hC080_EDA080, 5);     // overlong NUL, then a surrogate
        send_packed(64'hF4908080, 4);        // beyond U+10FFFF
        send_packed(64'hE441, 2);            // open sequence broken by 'A'
        send_packed(64'hE4B8, 2);            // sequence still open at end of string
        wait_for_totals();
    endtask

    task automatic test_random_text(input int n_bytes, input int src_pct, input int sink_pct,
                                    input int drain_pct);
        logic [20:0] c;
        logic        noisy;
        int          units;
        int          sent_here;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent_here      = 0;
        while (sent_here < n_bytes) begin
            noisy = ($urandom_range(99) < 30);
            units = $urandom_range(8, 1);
            for (int u = 0; u < units; u++) begin
                if (noisy && $urandom_range(99) < 40) begin
                    push_noise();
                end else begin
                    c = pick_codepoint();
                    push_utf8(c, utf8_len(c));
                end
            end
            sent_here += pending_text.size();
            send_pending();
            // sender holds off until the pipe has fully drained
            if ($urandom_range(99) < drain_pct) wait_for_totals();
        end
        wait_for_totals();
    endtask

    initial begin
        int guard;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_text(180, 61, 0, 0);
        test_random_text(180, 0, 61, 0);
        test_random_text(180, 14, 14, 20);
        test_random_text(180, 0, 0, 0);

        guard = 0;
        while (expected_totals.size() != 0 && guard < 10000) begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        if (expected_totals.size() != 0) begin
            $display("%0d totals never arrived", expected_totals.size());
            mismatches += expected_totals.size();
        end

        $display("Sent %0d strings in %0d bytes; %0d totals checked, %0d of them saturated.",
                 strings_sent, bytes_sent, totals_checked, saturated_seen);
        $display("Covered malformed, truncated and boundary text under four idle/stall mixes.");
        if (mismatches == 0) begin
            $display("** utf8_display_width_counter: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** utf8_display_width_counter: FAILED **");
        end
        $finish;
    end

endmodule
